### rtl/tcpl_pkg.sv
// Package for the three-class priority LIFO block.
// Holds sizes, codes, transaction structs and the memory address helper.
// No dependencies.
`default_nettype none

package tcpl_pkg;

  // Stack depth per class and derived widths.
  localparam int STACK_DEPTH = 16;
  localparam int CLASS_COUNT = 3;
  localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int FILL_W      = $clog2(STACK_DEPTH + 1);
  localparam int MEM_DEPTH   = CLASS_COUNT * STACK_DEPTH;
  localparam int MEM_AW      = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int TOTAL_W     = FILL_W + 2;

  // Function codes of an input transaction.
  localparam logic FUNC_PUSH  = 1'b0;
  localparam logic FUNC_SERVE = 1'b1;

  // Kind codes of a result transaction.
  localparam logic KIND_ENTRY  = 1'b0;
  localparam logic KIND_REJECT = 1'b1;

  // Priority class codes.
  localparam logic [1:0] CLS_HIGH = 2'd0;
  localparam logic [1:0] CLS_MID  = 2'd1;
  localparam logic [1:0] CLS_LOW  = 2'd2;

  typedef struct packed {
    logic        func;
    logic [1:0]  category;
    logic [15:0] item_id;
    logic signed [31:0] item_time;
    logic [5:0]  serve_count;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [1:0]  out_category;
    logic [15:0] out_id;
    logic signed [31:0] out_time;
    logic        last;
  } out_item_t;

  // One stored stack entry.
  typedef struct packed {
    logic [15:0] id;
    logic [31:0] stamp;
  } entry_t;

  // Control group from the sequencer to the entry memory.
  typedef struct packed {
    logic              wr_en;
    logic [MEM_AW-1:0] wr_addr;
    logic              rd_en;
    logic [MEM_AW-1:0] rd_addr;
  } mem_ctl_t;

  // Flat memory address of slot idx in the stack of class cls.
  function automatic logic [MEM_AW-1:0] mem_addr(input logic [1:0] cls,
                                                 input logic [IDX_W-1:0] idx);
    logic [MEM_AW+1:0] full;
    full = (MEM_AW+2)'(cls) * (MEM_AW+2)'(STACK_DEPTH) + (MEM_AW+2)'(idx);
    return full[MEM_AW-1:0];
  endfunction

endpackage

`default_nettype wire

### rtl/tcpl_mem.sv
// Entry memory shared by the three class stacks.
// One write port and one registered read port; uses tcpl_pkg.
`default_nettype none

module tcpl_mem
  import tcpl_pkg::*;
(
  input  wire logic     clk,
  input  wire mem_ctl_t ctl,
  input  wire entry_t   wr_data,
  output entry_t        rd_data
);

  entry_t mem [MEM_DEPTH];
  entry_t rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= wr_data;
    end
  end

  // Registered read port; data holds until the next read.
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data_r <= mem[ctl.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### rtl/three_class_priority_lifo.sv
// Top level of the three-class priority LIFO block.
// Uses tcpl_pkg and the entry memory tcpl_mem.
//
// Usage:
//   The input channel (in_valid/in_ready/in_item) carries push and serve
//   transactions. A push stores (id, time) on the stack of its class (class
//   code 3 goes to the low stack). A push to a full stack gives one reject
//   transaction with last set. A serve pops up to serve_count entries, newest
//   first, from the high, then middle, then low stack; each popped entry is
//   one result transaction and the final one carries last.
//   Results leave on out_valid/out_ready/out_item through an output register.
//
// Sequencing:
//   A push that fits leaves the sequencer idle, so in_ready stays high.
//   A rejected push goes to the reject state, which waits for a free output
//   register. A serve visits a pop state, which reads the entry memory port,
//   then a load state, which moves the registered read data into the output
//   register, for each popped entry. A serve with nothing to pop stays idle.
//   in_ready is high only while the sequencer is idle.
//
// Reset (rst_n low, synchronous) empties all three stacks and the output
// register. When the receiver stalls, the sequencer waits with the next
// entry in the memory read register until the output register frees.
`default_nettype none

module three_class_priority_lifo
  import tcpl_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_item
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_POP  = 4'b0010,
    S_LOAD = 4'b0100,
    S_REJ  = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [FILL_W-1:0] fill_r [CLASS_COUNT];
  logic [FILL_W-1:0] fill_nxt [CLASS_COUNT];
  logic [5:0]        want_r, want_nxt;
  logic [1:0]        cls_r, cls_nxt;
  logic              last_r, last_nxt;
  entry_t            hold_r, hold_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_item_r, out_item_nxt;

  logic              in_fire;
  logic              out_free;
  logic [1:0]        push_cls;
  logic              push_full;
  logic [1:0]        pop_cls;
  logic [FILL_W-1:0] pop_top;
  logic [TOTAL_W-1:0] total;
  entry_t            in_entry;
  entry_t            rd_data;
  mem_ctl_t          mem_ctl;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Class selection for a push (unused code maps to low) and for a pop.
  always_comb begin
    push_cls = (in_item.category inside {CLS_HIGH, CLS_MID}) ? in_item.category
                                                              : CLS_LOW;
    if (fill_r[CLS_HIGH] != '0) begin
      pop_cls = CLS_HIGH;
    end else if (fill_r[CLS_MID] != '0) begin
      pop_cls = CLS_MID;
    end else begin
      pop_cls = CLS_LOW;
    end
  end

  assign push_full = (fill_r[push_cls] == FILL_W'(STACK_DEPTH));
  assign pop_top   = fill_r[pop_cls] - 1'b1;
  assign total     = TOTAL_W'(fill_r[CLS_HIGH]) + TOTAL_W'(fill_r[CLS_MID])
                   + TOTAL_W'(fill_r[CLS_LOW]);
  assign in_entry  = '{id: in_item.item_id, stamp: in_item.item_time};

  // Memory control: write on an accepted push that fits, read on each pop.
  always_comb begin
    mem_ctl.wr_en   = in_fire && (in_item.func == FUNC_PUSH) && !push_full;
    mem_ctl.wr_addr = mem_addr(push_cls, fill_r[push_cls][IDX_W-1:0]);
    mem_ctl.rd_en   = (state_r == S_POP);
    mem_ctl.rd_addr = mem_addr(pop_cls, pop_top[IDX_W-1:0]);
  end

  tcpl_mem u_mem (
    .clk     (clk),
    .ctl     (mem_ctl),
    .wr_data (in_entry),
    .rd_data (rd_data)
  );

  // Sequencer and datapath next values.
  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    want_nxt      = want_r;
    cls_nxt       = cls_r;
    last_nxt      = last_r;
    hold_nxt      = hold_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_item_nxt  = out_item_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_item.func == FUNC_PUSH) begin
            if (push_full) begin
              cls_nxt   = push_cls;
              hold_nxt  = in_entry;
              state_nxt = S_REJ;
            end else begin
              fill_nxt[push_cls] = fill_r[push_cls] + 1'b1;
            end
          end else if ((in_item.serve_count != '0) && (total != '0)) begin
            want_nxt  = in_item.serve_count;
            state_nxt = S_POP;
          end
        end
      end
      S_POP: begin
        // Pop the newest entry of the highest non-empty class.
        fill_nxt[pop_cls] = pop_top;
        want_nxt          = want_r - 1'b1;
        cls_nxt           = pop_cls;
        last_nxt          = (want_r == 6'd1) || (total == TOTAL_W'(1));
        state_nxt         = S_LOAD;
      end
      S_LOAD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{kind: KIND_ENTRY, out_category: cls_r,
                            out_id: rd_data.id, out_time: rd_data.stamp,
                            last: last_r};
          state_nxt     = last_r ? S_IDLE : S_POP;
        end
      end
      S_REJ: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{kind: KIND_REJECT, out_category: cls_r,
                            out_id: hold_r.id, out_time: hold_r.stamp,
                            last: 1'b1};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CLASS_COUNT; i++) begin
        fill_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      fill_r      <= fill_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    want_r     <= want_nxt;
    cls_r      <= cls_nxt;
    last_r     <= last_nxt;
    hold_r     <= hold_nxt;
    out_item_r <= out_item_nxt;
  end

`ifndef SYNTHESIS
  // No stack ever holds more than its depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r[CLS_HIGH] <= FILL_W'(STACK_DEPTH)) &&
    (fill_r[CLS_MID] <= FILL_W'(STACK_DEPTH)) &&
    (fill_r[CLS_LOW] <= FILL_W'(STACK_DEPTH)))
    else $error("stack fill count exceeds depth");

  // A push to a full stack leads to the reject state.
  a_full_rejects: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_item.func == FUNC_PUSH) && push_full) |=> (state_r == S_REJ))
    else $error("full push did not enter reject state");

  // A reject transaction is always the last of its input transaction.
  a_reject_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_item_r.kind == KIND_REJECT)) |-> out_item_r.last)
    else $error("reject transaction without last");

  // A pop is only started while some stack holds an entry.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP) |-> (total != '0))
    else $error("pop from empty stacks");

  // A loaded entry from the memory appears as an entry transaction.
  a_load_kind: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_LOAD) && out_free) |=>
      (out_valid_r && (out_item_r.kind == KIND_ENTRY)))
    else $error("entry load did not produce an entry transaction");
`endif

endmodule

`default_nettype wire
